### hdl/pmatch_pkg.sv
// ----------------------------------------------------------------------------
// pmatch_pkg
// Shared types and constants of the parenthesis matcher: widths, bracket
// codes, mark kinds and the entry that travels from front end to back end.
// ----------------------------------------------------------------------------
package pmatch_pkg;

    // line and stack sizing
    localparam int STACK_DEPTH = 32;
    localparam int LINE_MAX    = 4096;
    localparam int QUEUE_DEPTH = 4;

    // field widths
    localparam int CODE_W   = 16;
    localparam int POS_W    = 12;
    localparam int KIND_W   = 2;
    localparam int CURSOR_W = POS_W + 1;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 16;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // derived widths
    localparam int IDX_W  = $clog2(LINE_MAX);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int SP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // largest reportable position and the overflow report position
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] OVF_POS = POS_W'((LINE_MAX - 1) % (1 << POS_W));

    // bracket character codes
    localparam logic [CODE_W-1:0] OPEN_CODE  = 16'h0028;
    localparam logic [CODE_W-1:0] CLOSE_CODE = 16'h0029;

    // mark kinds on the result stream
    localparam logic [KIND_W-1:0] KIND_UNMATCHED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CURSOR    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END       = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW  = 2'd3;

    // register index of the cursor register
    localparam logic [0:0] CFG_IDX_CURSOR = 1'b0;

    // operation decided by the front end
    typedef enum logic [1:0] {
        OP_NONE,
        OP_OPEN,
        OP_CLOSE,
        OP_OVF
    } op_t;

    // one queued operation
    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] pos;
        logic             line_end;
        logic [POS_W-1:0] len;
    } entry_t;

endpackage

### hdl/pmatch_front.sv
// ----------------------------------------------------------------------------
// pmatch_front
// Front end: accepts characters, tracks the character position and its
// saturation, and classifies each character into a queued operation.
// ----------------------------------------------------------------------------
module pmatch_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pmatch_pkg::CODE_W-1:0] char_code,
    input  logic                          line_end,
    input  logic                          q_full,
    output logic                          q_push,
    output pmatch_pkg::entry_t            q_data
);

    localparam int IW = pmatch_pkg::IDX_W;
    localparam int PW = pmatch_pkg::POS_W;
    localparam int WW = IW + PW + 1;

    logic [IW-1:0] char_index_reg;
    logic [IW-1:0] char_index_next;
    logic          saturated_reg;
    logic          saturated_next;

    logic          accept;
    logic          is_open;
    logic          is_close;
    logic [WW-1:0] idx_wide;
    logic [WW-1:0] len_wide;
    logic [PW-1:0] pos;
    logic [PW-1:0] len;
    pmatch_pkg::op_t op;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    // classify the character
    assign is_open  = (char_code == pmatch_pkg::OPEN_CODE);
    assign is_close = (char_code == pmatch_pkg::CLOSE_CODE);

    always_comb
    begin
        if (saturated_reg)
        begin
            op = (is_open || is_close) ? pmatch_pkg::OP_OVF : pmatch_pkg::OP_NONE;
        end
        else if (is_open)
        begin
            op = pmatch_pkg::OP_OPEN;
        end
        else if (is_close)
        begin
            op = pmatch_pkg::OP_CLOSE;
        end
        else
        begin
            op = pmatch_pkg::OP_NONE;
        end
    end

    // position and saturated line length
    assign idx_wide = {{(PW + 1){1'b0}}, char_index_reg};
    assign len_wide = idx_wide + WW'(1);
    assign pos      = idx_wide[PW-1:0];
    assign len      = (saturated_reg || (len_wide > WW'(pmatch_pkg::POS_MAX)))
                      ? pmatch_pkg::POS_MAX : len_wide[PW-1:0];

    // only items that can cause a result go to the queue
    assign q_push        = accept && ((op != pmatch_pkg::OP_NONE) || line_end);
    assign q_data.op       = op;
    assign q_data.pos      = saturated_reg ? pmatch_pkg::OVF_POS : pos;
    assign q_data.line_end = line_end;
    assign q_data.len      = len;

    // position counter update
    always_comb
    begin
        char_index_next = char_index_reg;
        saturated_next  = saturated_reg;
        if (accept)
        begin
            if (line_end)
            begin
                char_index_next = '0;
                saturated_next  = 1'b0;
            end
            else if (!saturated_reg)
            begin
                if (char_index_reg >= IW'(pmatch_pkg::LINE_MAX - 1))
                begin
                    saturated_next = 1'b1;
                end
                else
                begin
                    char_index_next = char_index_reg + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_index_reg <= '0;
            saturated_reg  <= 1'b0;
        end
        else
        begin
            char_index_reg <= char_index_next;
            saturated_reg  <= saturated_next;
        end
    end

endmodule

### hdl/pmatch_queue.sv
// ----------------------------------------------------------------------------
// pmatch_queue
// Short queue of operations between the front end and the back end.
// ----------------------------------------------------------------------------
module pmatch_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pmatch_pkg::entry_t push_data,
    output logic               full,
    input  logic               pop,
    output pmatch_pkg::entry_t head,
    output logic               empty
);

    localparam int DEPTH = pmatch_pkg::QUEUE_DEPTH;
    localparam int PTR_W = pmatch_pkg::QPTR_W;
    localparam int CNT_W = pmatch_pkg::QCNT_W;

    pmatch_pkg::entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/pmatch_back.sv
// ----------------------------------------------------------------------------
// pmatch_back
// Back end: runs the opener stack, reports unmatched, cursor-matched and
// overflow brackets, and flushes the stack at the end of a line.
// ----------------------------------------------------------------------------
module pmatch_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  pmatch_pkg::entry_t              q_head,
    input  logic                            q_empty,
    output logic                            q_pop,
    input  logic [pmatch_pkg::CURSOR_W-1:0] cursor,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [pmatch_pkg::POS_W-1:0]    out_pos,
    output logic [pmatch_pkg::KIND_W-1:0]   out_kind,
    output logic                            out_last
);

    localparam int PW = pmatch_pkg::POS_W;
    localparam int CW = pmatch_pkg::CNT_W;
    localparam int SW = pmatch_pkg::SP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CURSOR2,
        ST_FLUSH
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [PW-1:0]    stack_reg [pmatch_pkg::STACK_DEPTH];
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [PW-1:0]    cur_pos_reg;
    logic [PW-1:0]    cur_pos_next;
    logic             cur_end_reg;
    logic             cur_end_next;
    logic [PW-1:0]    cur_len_reg;
    logic [PW-1:0]    cur_len_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [PW-1:0]    out_pos_reg;
    logic [PW-1:0]    out_pos_next;
    logic [pmatch_pkg::KIND_W-1:0] out_kind_reg;
    logic [pmatch_pkg::KIND_W-1:0] out_kind_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic             can_emit;
    logic [CW-1:0]    count_m1;
    logic [SW-1:0]    top_idx;
    logic [PW-1:0]    top_pos;
    logic             push_en;
    logic [SW-1:0]    push_idx;
    logic             top_at_cursor;
    logic             pos_at_cursor;

    // top of stack
    assign count_m1 = count_reg - CW'(1);
    assign top_idx  = count_m1[SW-1:0];
    assign top_pos  = stack_reg[top_idx];
    assign push_idx = count_reg[SW-1:0];

    // cursor hits, a negative cursor never matches
    assign top_at_cursor = !cursor[PW] && (cursor[PW-1:0] == top_pos);
    assign pos_at_cursor = !cursor[PW] && (cursor[PW-1:0] == q_head.pos);

    // a step may run when the output register is free or draining
    assign can_emit = !out_valid_reg || out_ready;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cur_pos_next   = cur_pos_reg;
        cur_end_next   = cur_end_reg;
        cur_len_next   = cur_len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_pos_next   = out_pos_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        push_en        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && can_emit)
                begin
                    q_pop        = 1'b1;
                    cur_pos_next = q_head.pos;
                    cur_end_next = q_head.line_end;
                    cur_len_next = q_head.len;
                    unique case (q_head.op)
                        pmatch_pkg::OP_OVF:
                        begin
                            out_valid_next = 1'b1;
                            out_pos_next   = q_head.pos;
                            out_kind_next  = pmatch_pkg::KIND_OVERFLOW;
                            out_last_next  = !q_head.line_end;
                        end
                        pmatch_pkg::OP_OPEN:
                        begin
                            if (count_reg >= CW'(pmatch_pkg::STACK_DEPTH))
                            begin
                                out_valid_next = 1'b1;
                                out_pos_next   = q_head.pos;
                                out_kind_next  = pmatch_pkg::KIND_OVERFLOW;
                                out_last_next  = !q_head.line_end;
                            end
                            else
                            begin
                                push_en    = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        pmatch_pkg::OP_CLOSE:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_pos_next   = q_head.pos;
                                out_kind_next  = pmatch_pkg::KIND_UNMATCHED;
                                out_last_next  = !q_head.line_end;
                            end
                            else
                            begin
                                count_next = count_m1;
                                if (top_at_cursor || pos_at_cursor)
                                begin
                                    out_valid_next = 1'b1;
                                    out_pos_next   = top_pos;
                                    out_kind_next  = pmatch_pkg::KIND_CURSOR;
                                    out_last_next  = 1'b0;
                                    state_next     = ST_CURSOR2;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    // end of line goes on to the flush unless a pair is pending
                    if (q_head.line_end && (state_next == ST_IDLE))
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_CURSOR2:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_pos_next   = cur_pos_reg;
                    out_kind_next  = pmatch_pkg::KIND_CURSOR;
                    out_last_next  = !cur_end_reg;
                    state_next     = cur_end_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    if (count_reg != '0)
                    begin
                        out_pos_next  = top_pos;
                        out_kind_next = pmatch_pkg::KIND_UNMATCHED;
                        out_last_next = 1'b0;
                        count_next    = count_m1;
                    end
                    else
                    begin
                        out_pos_next  = cur_len_reg;
                        out_kind_next = pmatch_pkg::KIND_END;
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers and stack storage
    always_ff @(posedge clk)
    begin
        cur_pos_reg  <= cur_pos_next;
        cur_end_reg  <= cur_end_next;
        cur_len_reg  <= cur_len_next;
        out_pos_reg  <= out_pos_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        if (push_en)
        begin
            stack_reg[push_idx] <= q_head.pos;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pos   = out_pos_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;

endmodule

### hdl/parenthesis_matcher_core.sv
// ----------------------------------------------------------------------------
// parenthesis_matcher_core
// Bracket matcher over one line of text fed one character per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one character per transaction: tdata = UTF-16 code, tlast
//   marks the last character of the line. m_axis carries marks: tdata =
//   position, tuser = mark kind, tlast = final mark caused by a character.
//   The APB port holds the cursor position register (address 0, 13-bit
//   signed, -1 = no cursor); write it only while the block is idle.
// Flow:
//   A character is taken per cycle while the four-entry operation queue has
//   room. The back end handles each queued character in turn, gives the
//   second mark of a cursor pair as a further step, and at end of line one
//   mark per leftover opener, then the end marker. The first mark is held in
//   the operation queue and then in the output register before it is valid.
// Reset:
//   Clears the queue, stack count, position counter and output register;
//   the cursor returns to -1.
// Stall:
//   A stalled m_axis holds its mark; the back end stops, the queue fills,
//   then s_axis tready drops.
// ----------------------------------------------------------------------------
module parenthesis_matcher_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // character stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pmatch_pkg::TDATA_IN_W-1:0]  s_axis_tdata,  // [15:0] char_code
    input  logic                               s_axis_tlast,
    // mark stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pmatch_pkg::TDATA_OUT_W-1:0] m_axis_tdata,  // [11:0] position
    output logic [pmatch_pkg::KIND_W-1:0]      m_axis_tuser,  // [1:0] mark_kind
    output logic                               m_axis_tlast,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pmatch_pkg::APB_AW-1:0]      paddr,
    input  logic [pmatch_pkg::APB_DW-1:0]      pwdata,
    output logic [pmatch_pkg::APB_DW-1:0]      prdata,
    output logic                               pready
);

    localparam int CUW = pmatch_pkg::CURSOR_W;
    localparam int PW  = pmatch_pkg::POS_W;

    logic [CUW-1:0]     cursor_reg;
    logic [CUW-1:0]     cursor_next;
    logic               cfg_hit;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    pmatch_pkg::entry_t q_in;
    pmatch_pkg::entry_t q_head;
    logic [PW-1:0]      out_pos;

    // cursor register
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[pmatch_pkg::APB_AW-1] == pmatch_pkg::CFG_IDX_CURSOR);

    always_comb
    begin
        cursor_next = cursor_reg;
        if (psel && penable && pwrite && cfg_hit)
        begin
            cursor_next = pwdata[CUW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= {CUW{1'b1}};
        end
        else
        begin
            cursor_reg <= cursor_next;
        end
    end

    // register read back, sign extended
    assign prdata = cfg_hit ? {{(pmatch_pkg::APB_DW - CUW){cursor_reg[CUW-1]}}, cursor_reg}
                            : '0;

    pmatch_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .char_code (s_axis_tdata[pmatch_pkg::CODE_W-1:0]),
        .line_end  (s_axis_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    pmatch_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    pmatch_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .cursor    (cursor_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pos   (out_pos),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(pmatch_pkg::TDATA_OUT_W - PW){1'b0}}, out_pos};

endmodule
